>>> hw/rtl/input_bundle_frame_checker_unit_assert.svh
// Assertion macros for the frame checker. Both sample on posedge clk.
`ifndef INPUT_BUNDLE_FRAME_CHECKER_UNIT_ASSERT_SVH
`define INPUT_BUNDLE_FRAME_CHECKER_UNIT_ASSERT_SVH
// Property held outside reset.
`define IBFC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("frame checker assertion failed");
// Property held at every edge, reset included.
`define IBFC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("frame checker assertion failed");
`endif

>>> hw/rtl/ibfc_pkg.sv
// ----------------------------------------------------------------------------
// ibfc_pkg
// Shared types and constants of the input bundle frame checker.
// ----------------------------------------------------------------------------
`default_nettype none
package ibfc_pkg;

  localparam int MAX_SAMPLES_DEF = 3;
  localparam int HEADER_BYTES    = 24;
  localparam int SAMPLE_BYTES    = 28;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SIZE   = 3'd1,
    ST_SCHEMA = 3'd2,
    ST_COUNT  = 3'd3,
    ST_INPUT  = 3'd4,
    ST_ORDER  = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCHEMA    = 3'd0,
    REG_KNOWN     = 3'd1,
    REG_GEAR_UP   = 3'd2,
    REG_GEAR_DOWN = 3'd3,
    REG_STANDING  = 3'd4,
    REG_DUCKING   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] schema_version;
    logic [15:0] known_flag_mask;
    logic [15:0] gear_up_mask;
    logic [15:0] gear_down_mask;
    logic [15:0] standing_mask;
    logic [15:0] ducking_mask;
  } cfg_t;

  typedef struct packed {
    logic [63:0] tick;
    logic [63:0] seq;
    logic [63:0] controls;
    logic [15:0] flags;
  } sample_t;

  // Frame completion handed from the parser to the result stage.
  typedef struct packed {
    logic    done;
    status_t status;
  } done_t;

endpackage
`default_nettype wire

>>> hw/rtl/ibfc_in_if.sv
// ----------------------------------------------------------------------------
// ibfc_in_if
// Byte stream channel into the frame checker.
// ----------------------------------------------------------------------------
`default_nettype none
interface ibfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/ibfc_out_if.sv
// ----------------------------------------------------------------------------
// ibfc_out_if
// Result channel out of the frame checker.
// ----------------------------------------------------------------------------
`default_nettype none
interface ibfc_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [1:0]         sample_index;
  logic [63:0]        requested_tick;
  logic [63:0]        input_sequence;
  logic [14:0]        throttle;
  logic [14:0]        brake;
  logic signed [15:0] steer;
  logic signed [15:0] lean;
  logic [15:0]        sample_flags;
  logic [63:0]        connection_serial;
  logic [31:0]        connection_generation;
  logic               last;

  modport source (output valid, output status, output sample_index,
                  output requested_tick, output input_sequence, output throttle,
                  output brake, output steer, output lean, output sample_flags,
                  output connection_serial, output connection_generation,
                  output last, input ready);
  modport sink (input valid, input status, input sample_index,
                input requested_tick, input input_sequence, input throttle,
                input brake, input steer, input lean, input sample_flags,
                input connection_serial, input connection_generation,
                input last, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/ibfc_parse.sv
// ----------------------------------------------------------------------------
// ibfc_parse
// Absorbs one frame byte per cycle while accept is high, checks header and
// samples, and shows the snapshot in the cycle the end-of-frame byte is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module ibfc_parse #(
  parameter int MAX_SAMPLES = ibfc_pkg::MAX_SAMPLES_DEF,
  parameter int CNT_W       = $clog2(MAX_SAMPLES + 1)
) (
  input  wire                   clk,
  input  wire                   rst,
  input  ibfc_pkg::cfg_t        cfg,
  input  wire                   accept,
  input  wire  [7:0]            data_byte,
  input  wire                   frame_end,
  output ibfc_pkg::done_t       done,
  output logic [CNT_W-1:0]      snap_count,
  output logic [63:0]           snap_serial,
  output logic [31:0]           snap_generation,
  output ibfc_pkg::sample_t     snap [MAX_SAMPLES]
);
  import ibfc_pkg::*;

  localparam int FRAME_BYTES = HEADER_BYTES + SAMPLE_BYTES * MAX_SAMPLES;
  localparam int SLOT_W      = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  logic [7:0]        pos, pos_next;
  logic [31:0]       shift, shift_next;
  status_t           err, err_next;
  logic [31:0]       hcount, hcount_next;
  logic [63:0]       hserial, hserial_next;
  logic [31:0]       hgen, hgen_next;
  logic [SLOT_W-1:0] slot, slot_next;
  logic [4:0]        off, off_next;
  sample_t           cur, cur_next;
  logic [15:0]       cur_res, cur_res_next;
  logic [63:0]       prev_tick, prev_tick_next;
  logic [63:0]       prev_seq, prev_seq_next;
  logic              store_we;
  sample_t           store [MAX_SAMPLES];

  logic [15:0] thr, brk, str, lea, fl;
  logic        smp_ok;

  always_comb begin
    thr = cur_next.controls[15:0];
    brk = cur_next.controls[31:16];
    str = cur_next.controls[47:32];
    lea = cur_next.controls[63:48];
    fl  = cur_next.flags;
    smp_ok = (cur_next.tick != '0) && (cur_next.seq != '0)
          && (thr <= 16'd32767) && (brk <= 16'd32767)
          && (str != 16'h8000) && (lea != 16'h8000)
          && ((fl & ~cfg.known_flag_mask) == '0)
          && (cur_res_next == '0)
          && !(((fl & cfg.gear_up_mask) != '0) && ((fl & cfg.gear_down_mask) != '0))
          && !(((fl & cfg.standing_mask) != '0) && ((fl & cfg.ducking_mask) != '0));
  end

  always_comb begin
    pos_next       = pos;
    shift_next     = shift;
    err_next       = err;
    hcount_next    = hcount;
    hserial_next   = hserial;
    hgen_next      = hgen;
    slot_next      = slot;
    off_next       = off;
    cur_next       = cur;
    cur_res_next   = cur_res;
    prev_tick_next = prev_tick;
    prev_seq_next  = prev_seq;
    store_we       = 1'b0;
    if (accept && (pos < 8'(FRAME_BYTES))) begin
      if (pos < 8'(HEADER_BYTES)) begin
        if (pos < 8'd4) begin
          if (pos == 8'd0) shift_next = '0;
          shift_next[8*pos[1:0] +: 8] = data_byte;
          if (pos == 8'd3 && shift_next != cfg.schema_version && err == ST_OK)
            err_next = ST_SCHEMA;
        end else if (pos < 8'd8) begin
          hcount_next[8*pos[1:0] +: 8] = data_byte;
          if (pos == 8'd7 && err == ST_OK &&
              (hcount_next == '0 || hcount_next > 32'(MAX_SAMPLES)))
            err_next = ST_COUNT;
        end else if (pos < 8'd16) begin
          hserial_next[8*pos[2:0] +: 8] = data_byte;
        end else if (pos < 8'd20) begin
          hgen_next[8*pos[1:0] +: 8] = data_byte;
        end else begin
          if (pos == 8'd20) shift_next = '0;
          shift_next[8*pos[1:0] +: 8] = data_byte;
          if (pos == 8'd23 && err == ST_OK &&
              (hserial == '0 || hgen == '0 || shift_next != '0))
            err_next = ST_INPUT;
        end
      end else begin
        // Sample body: start each slot from zero
        if (off == 5'd0) begin
          cur_next     = '0;
          cur_res_next = '0;
        end
        if (off < 5'd8)       cur_next.tick[8*off[2:0] +: 8]     = data_byte;
        else if (off < 5'd16) cur_next.seq[8*off[2:0] +: 8]      = data_byte;
        else if (off < 5'd24) cur_next.controls[8*off[2:0] +: 8] = data_byte;
        else if (off < 5'd26) cur_next.flags[8*off[0] +: 8]      = data_byte;
        else                  cur_res_next[8*off[0] +: 8]        = data_byte;
        if (off == 5'(SAMPLE_BYTES - 1)) begin
          off_next       = '0;
          slot_next      = slot + SLOT_W'(1);
          store_we       = 1'b1;
          prev_tick_next = cur_next.tick;
          prev_seq_next  = cur_next.seq;
          if (err == ST_OK) begin
            if (32'(slot) < hcount) begin
              if (!smp_ok)
                err_next = ST_INPUT;
              else if (slot != '0 && (prev_tick >= cur_next.tick ||
                                      prev_seq >= cur_next.seq))
                err_next = ST_ORDER;
            end else if ((cur_next.tick | cur_next.seq | cur_next.controls
                          | 64'(cur_next.flags) | 64'(cur_res_next)) != '0) begin
              err_next = ST_INPUT;
            end
          end
        end else begin
          off_next = off + 5'd1;
        end
      end
    end
    if (accept && (pos <= 8'(FRAME_BYTES))) pos_next = pos + 8'd1;
  end

  // Snapshot of the frame as it stands after this byte
  always_comb begin
    done.done   = accept && frame_end;
    done.status = (pos_next != 8'(FRAME_BYTES)) ? ST_SIZE : err_next;
    snap_count      = hcount_next[CNT_W-1:0];
    snap_serial     = hserial_next;
    snap_generation = hgen_next;
    for (int j = 0; j < MAX_SAMPLES; j++) begin
      snap[j] = (store_we && slot == SLOT_W'(j)) ? cur_next : store[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      shift   <= '0;
      err     <= ST_OK;
      hcount  <= '0;
      hserial <= '0;
      hgen    <= '0;
      slot    <= '0;
      off     <= '0;
    end else if (accept && frame_end) begin
      pos     <= '0;
      shift   <= '0;
      err     <= ST_OK;
      hcount  <= '0;
      hserial <= '0;
      hgen    <= '0;
      slot    <= '0;
      off     <= '0;
    end else begin
      pos     <= pos_next;
      shift   <= shift_next;
      err     <= err_next;
      hcount  <= hcount_next;
      hserial <= hserial_next;
      hgen    <= hgen_next;
      slot    <= slot_next;
      off     <= off_next;
    end
  end

  always_ff @(posedge clk) begin
    cur       <= cur_next;
    cur_res   <= cur_res_next;
    prev_tick <= prev_tick_next;
    prev_seq  <= prev_seq_next;
    if (store_we) store[slot] <= cur_next;
  end

endmodule
`default_nettype wire

>>> hw/rtl/ibfc_emit.sv
// ----------------------------------------------------------------------------
// ibfc_emit
// Holds the snapshot of a finished frame and hands out its result words.
// ----------------------------------------------------------------------------
`default_nettype none
module ibfc_emit #(
  parameter int MAX_SAMPLES = ibfc_pkg::MAX_SAMPLES_DEF,
  parameter int CNT_W       = $clog2(MAX_SAMPLES + 1)
) (
  input  wire                   clk,
  input  wire                   rst,
  input  ibfc_pkg::done_t       done,
  input  wire  [CNT_W-1:0]      snap_count,
  input  wire  [63:0]           snap_serial,
  input  wire  [31:0]           snap_generation,
  input  ibfc_pkg::sample_t     snap [MAX_SAMPLES],
  output logic                  busy,
  ibfc_out_if.source            result
);
  import ibfc_pkg::*;

  localparam int SLOT_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  logic              full;
  logic [SLOT_W-1:0] idx;
  status_t           status_r;
  logic [CNT_W-1:0]  count_r;
  logic [63:0]       serial_r;
  logic [31:0]       gen_r;
  sample_t           held [MAX_SAMPLES];
  sample_t           sel;
  logic              is_last;
  logic              is_err;

  always_comb begin
    sel     = held[idx];
    is_err  = (status_r != ST_OK);
    is_last = is_err || ((CNT_W'(idx) + CNT_W'(1)) == count_r);
    busy    = full;

    result.valid                 = full;
    result.status                = status_r;
    result.last                  = is_last;
    result.sample_index          = is_err ? 2'd0 : 2'(idx);
    result.requested_tick        = is_err ? '0 : sel.tick;
    result.input_sequence        = is_err ? '0 : sel.seq;
    result.throttle              = is_err ? '0 : sel.controls[14:0];
    result.brake                 = is_err ? '0 : sel.controls[30:16];
    result.steer                 = is_err ? '0 : sel.controls[47:32];
    result.lean                  = is_err ? '0 : sel.controls[63:48];
    result.sample_flags          = is_err ? '0 : sel.flags;
    result.connection_serial     = is_err ? '0 : serial_r;
    result.connection_generation = is_err ? '0 : gen_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= '0;
    end else if (done.done) begin
      full <= 1'b1;
      idx  <= '0;
    end else if (full && result.ready) begin
      if (is_last) full <= 1'b0;
      else idx <= idx + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (done.done) begin
      status_r <= done.status;
      count_r  <= snap_count;
      serial_r <= snap_serial;
      gen_r    <= snap_generation;
      for (int j = 0; j < MAX_SAMPLES; j++) held[j] <= snap[j];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/input_bundle_frame_checker_unit.sv
// ----------------------------------------------------------------------------
// input_bundle_frame_checker_unit
// Checks a byte-serial input bundle frame and emits its samples or an error.
// ----------------------------------------------------------------------------
// One frame byte is taken every cycle; each byte is absorbed and checked in
// a single pass of fixed logic. On the end-of-frame byte the frame is copied
// into a result buffer, which then hands out one result word per active
// sample (or one error word) per cycle while result.ready is high, and the
// next frame's bytes keep flowing in. Only an end-of-frame byte waits, and
// only while the buffer still holds words of the previous frame.
`default_nettype none
module input_bundle_frame_checker_unit #(
  parameter int MAX_SAMPLES = ibfc_pkg::MAX_SAMPLES_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  ibfc_in_if.sink                            frame,
  ibfc_out_if.source                         result,
  input  wire                                cfg_we,
  input  wire  [ibfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [ibfc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ibfc_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

  cfg_t             cfg;
  done_t            done;
  logic [CNT_W-1:0] snap_count;
  logic [63:0]      snap_serial;
  logic [31:0]      snap_generation;
  sample_t          snap [MAX_SAMPLES];
  logic             busy;
  logic             accept;

  assign frame.ready = !busy || !frame.frame_end;
  assign accept      = frame.valid && frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.schema_version  <= 32'd1;
      cfg.known_flag_mask <= 16'd15;
      cfg.gear_up_mask    <= 16'd1;
      cfg.gear_down_mask  <= 16'd2;
      cfg.standing_mask   <= 16'd4;
      cfg.ducking_mask    <= 16'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCHEMA:    cfg.schema_version  <= cfg_data;
        REG_KNOWN:     cfg.known_flag_mask <= cfg_data[15:0];
        REG_GEAR_UP:   cfg.gear_up_mask    <= cfg_data[15:0];
        REG_GEAR_DOWN: cfg.gear_down_mask  <= cfg_data[15:0];
        REG_STANDING:  cfg.standing_mask   <= cfg_data[15:0];
        REG_DUCKING:   cfg.ducking_mask    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  ibfc_parse #(.MAX_SAMPLES(MAX_SAMPLES), .CNT_W(CNT_W)) u_parse (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .accept          (accept),
    .data_byte       (frame.data_byte),
    .frame_end       (frame.frame_end),
    .done            (done),
    .snap_count      (snap_count),
    .snap_serial     (snap_serial),
    .snap_generation (snap_generation),
    .snap            (snap)
  );

  ibfc_emit #(.MAX_SAMPLES(MAX_SAMPLES), .CNT_W(CNT_W)) u_emit (
    .clk             (clk),
    .rst             (rst),
    .done            (done),
    .snap_count      (snap_count),
    .snap_serial     (snap_serial),
    .snap_generation (snap_generation),
    .snap            (snap),
    .busy            (busy),
    .result          (result)
  );

endmodule
`default_nettype wire

>>> hw/rtl/ibfc_checker.sv
// ----------------------------------------------------------------------------
// ibfc_checker
// Port-level checks of the frame checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "input_bundle_frame_checker_unit_assert.svh"
module ibfc_checker (
  input wire       clk,
  input wire       rst,
  input wire       out_valid,
  input wire       out_ready,
  input wire [2:0] status,
  input wire [1:0] sample_index,
  input wire       last
);
  import ibfc_pkg::*;

  `IBFC_ASSERT_ALWAYS(a_idle_after_reset, rst |=> !out_valid)
  `IBFC_ASSERT(a_status_range, out_valid |-> (status <= 3'(ST_ORDER)))
  `IBFC_ASSERT(a_error_is_last, (out_valid && status != 3'(ST_OK)) |-> last)
  `IBFC_ASSERT(a_error_index_zero, (out_valid && status != 3'(ST_OK)) |-> (sample_index == 2'd0))
  `IBFC_ASSERT(a_hold_when_stalled, (out_valid && !out_ready) |=> out_valid)

endmodule

bind input_bundle_frame_checker_unit ibfc_checker u_ibfc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .status       (result.status),
  .sample_index (result.sample_index),
  .last         (result.last)
);
`default_nettype wire
